>>> rtl/core/u8u16_pkg.sv
`timescale 1ns / 1ps

package u8u16_pkg;

  // Code unit constants
  localparam logic [15:0] REPL_CHAR = 16'hFFFD;
  localparam logic [15:0] HI_SURR   = 16'hD800;
  localparam logic [15:0] LO_SURR   = 16'hDC00;
  localparam logic [20:0] SMP_BASE  = 21'h10000;
  localparam logic [7:0]  LEAD_LIM  = 8'hF5;

  // Result queue geometry
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // One UTF-16 result
  typedef struct packed {
    logic [15:0] code_unit;
    logic        replaced;
    logic        last_of_run;
  } unit_t;

  // Results of one byte, handed from decoder to queue
  typedef struct packed {
    logic             valid;
    logic [1:0]       count;
    unit_t [1:0]      units;
  } push_t;

  // Outcome of handling one byte as a lead byte
  typedef struct packed {
    logic        emit;
    unit_t       unit;
    logic        load;
    logic [20:0] bits;
    logic [1:0]  pend;
  } lead_t;

  function automatic lead_t lead_decode(input logic [7:0] b, input logic fin);
    lead_t r;
    r = '0;
    if (b[7] == 1'b0) begin
      r.emit = 1'b1;
      r.unit.code_unit = {8'h00, b};
    end else if (b[7:6] == 2'b10 || b >= LEAD_LIM) begin
      r.emit = 1'b1;
      r.unit.code_unit = REPL_CHAR;
      r.unit.replaced = 1'b1;
    end else if (fin) begin
      // multi-byte lead cut off by the end of the string
      r.emit = 1'b1;
      r.unit.code_unit = REPL_CHAR;
      r.unit.replaced = 1'b1;
    end else begin
      r.load = 1'b1;
      if (b[5] == 1'b0) begin
        r.bits = {16'h0000, b[4:0]};
        r.pend = 2'd1;
      end else if (b[4] == 1'b0) begin
        r.bits = {17'd0, b[3:0]};
        r.pend = 2'd2;
      end else begin
        r.bits = {18'd0, b[2:0]};
        r.pend = 2'd3;
      end
    end
    return r;
  endfunction

endpackage

>>> rtl/core/u8u16_decode.sv
`timescale 1ns / 1ps

module u8u16_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_valid,
  output logic              s_ready,
  input  logic [7:0]        s_byte,
  input  logic              s_end,
  input  logic              first_only,
  input  logic              room,
  output u8u16_pkg::push_t  push
);

  logic              in_valid;
  logic [7:0]        in_byte;
  logic              in_end;
  logic              advance;

  logic [20:0]       partial_point;
  logic [1:0]        bytes_pending;
  logic              first_done;
  logic [20:0]       partial_point_next;
  logic [1:0]        bytes_pending_next;
  logic              first_done_next;

  u8u16_pkg::unit_t [1:0] units;
  u8u16_pkg::unit_t       repl;
  u8u16_pkg::lead_t       lead;
  logic [1:0]        n;
  logic              cont;
  logic [20:0]       acc;
  logic [1:0]        pend_dec;
  logic [20:0]       v;

  assign advance = in_valid && room;
  assign s_ready = !in_valid || room;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_valid && s_ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
    if (s_valid && s_ready) begin
      in_byte <= s_byte;
      in_end  <= s_end;
    end
  end

  // Decode one byte against the gathered sequence
  always_comb begin
    partial_point_next = partial_point;
    bytes_pending_next = bytes_pending;
    first_done_next    = first_done;
    units = '0;
    n     = 2'd0;
    repl  = '{code_unit: u8u16_pkg::REPL_CHAR, replaced: 1'b1, last_of_run: 1'b0};
    lead  = u8u16_pkg::lead_decode(in_byte, in_end);
    cont  = (in_byte[7:6] == 2'b10);
    acc   = {partial_point[14:0], in_byte[5:0]};
    pend_dec = bytes_pending - 2'd1;
    v     = acc - u8u16_pkg::SMP_BASE;

    if (first_done) begin
      // drop the rest of the string
    end else if (bytes_pending != 2'd0) begin
      if (cont) begin
        partial_point_next = acc;
        bytes_pending_next = pend_dec;
        if (pend_dec == 2'd0) begin
          partial_point_next = '0;
          if (acc < u8u16_pkg::SMP_BASE) begin
            units[0].code_unit = acc[15:0];
            n = 2'd1;
          end else begin
            units[0].code_unit = {5'b00000, v[20:10]} + u8u16_pkg::HI_SURR;
            units[1].code_unit = u8u16_pkg::LO_SURR | {6'b000000, v[9:0]};
            n = 2'd2;
          end
        end else if (in_end) begin
          units[0] = repl;
          n = 2'd1;
          partial_point_next = '0;
          bytes_pending_next = 2'd0;
        end
      end else begin
        // broken sequence: replace, then retry the byte as a lead unless first_only is set
        units[0] = repl;
        n = 2'd1;
        partial_point_next = '0;
        bytes_pending_next = 2'd0;
        if (!first_only) begin
          if (lead.emit) begin
            units[1] = lead.unit;
            n = 2'd2;
          end
          if (lead.load) begin
            partial_point_next = lead.bits;
            bytes_pending_next = lead.pend;
          end
        end
      end
    end else begin
      if (lead.emit) begin
        units[0] = lead.unit;
        n = 2'd1;
      end
      if (lead.load) begin
        partial_point_next = lead.bits;
        bytes_pending_next = lead.pend;
      end
    end

    if (n != 2'd0 && first_only) begin
      first_done_next = 1'b1;
    end
    if (in_end) begin
      partial_point_next = '0;
      bytes_pending_next = 2'd0;
      first_done_next    = 1'b0;
    end

    // flag the final unit of this byte
    if (n == 2'd1) begin
      units[0].last_of_run = 1'b1;
    end else if (n == 2'd2) begin
      units[1].last_of_run = 1'b1;
    end
  end

  assign push.valid = advance && (n != 2'd0);
  assign push.count = n;
  assign push.units = units;

  // Sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      partial_point <= '0;
      bytes_pending <= 2'd0;
      first_done    <= 1'b0;
    end else if (advance) begin
      partial_point <= partial_point_next;
      bytes_pending <= bytes_pending_next;
      first_done    <= first_done_next;
    end
  end

  // End of string leaves a clean state
  assert property (@(posedge clk) disable iff (rst)
    advance && in_end |=> bytes_pending == 2'd0 && !first_done && partial_point == '0)
    else $error("state not cleared at end of string");

  // Only the final unit of a pair carries the run flag
  assert property (@(posedge clk) disable iff (rst)
    push.valid && push.count == 2'd2 |->
      push.units[1].last_of_run && !push.units[0].last_of_run)
    else $error("run flag misplaced on unit pair");

  // Ignored bytes produce nothing
  assert property (@(posedge clk) disable iff (rst)
    first_done |-> n == 2'd0)
    else $error("output produced after first character");

endmodule

>>> rtl/core/u8u16_outq.sv
`timescale 1ns / 1ps

module u8u16_outq (
  input  logic              clk,
  input  logic              rst,
  input  u8u16_pkg::push_t  push,
  output logic              room,
  output logic              m_valid,
  input  logic              m_ready,
  output u8u16_pkg::unit_t  m_unit
);

  u8u16_pkg::unit_t mem [u8u16_pkg::QUEUE_DEPTH];
  logic [u8u16_pkg::QPTR_W-1:0] wr_ptr;
  logic [u8u16_pkg::QPTR_W-1:0] rd_ptr;
  logic [u8u16_pkg::QCNT_W-1:0] count;
  logic [1:0]                   push_cnt;
  logic                         pop;

  assign push_cnt = push.valid ? push.count : 2'd0;
  assign pop      = m_valid && m_ready;
  assign m_valid  = (count != '0);
  assign m_unit   = mem[rd_ptr];
  assign room     = (count <= u8u16_pkg::QCNT_W'(u8u16_pkg::QUEUE_DEPTH - 2));

  // Store up to two units per cycle
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wr_ptr] <= push.units[0];
    end
    if (push_cnt == 2'd2) begin
      mem[wr_ptr + u8u16_pkg::QPTR_W'(1)] <= push.units[1];
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + u8u16_pkg::QPTR_W'(push_cnt);
      rd_ptr <= rd_ptr + u8u16_pkg::QPTR_W'(pop);
      count  <= count + u8u16_pkg::QCNT_W'(push_cnt) - u8u16_pkg::QCNT_W'(pop);
    end
  end

  // A push never overruns the queue
  assert property (@(posedge clk) disable iff (rst)
    push.valid |-> {1'b0, count} + {2'b00, push.count} <=
      (u8u16_pkg::QCNT_W+1)'(u8u16_pkg::QUEUE_DEPTH))
    else $error("result queue overrun");

  // Occupancy stays within depth
  assert property (@(posedge clk) disable iff (rst)
    count <= u8u16_pkg::QCNT_W'(u8u16_pkg::QUEUE_DEPTH))
    else $error("result queue count out of range");

  // Occupancy tracks transfers
  assert property (@(posedge clk) disable iff (rst)
    !push.valid && !pop && !$past(rst) |=> $stable(count) || $past(push.valid) || $past(pop))
    else $error("result queue count changed without a transfer");

endmodule

>>> rtl/core/utf8_to_utf16_transcoder_top.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake                 Payload
// s_axis    in   s_axis_tvalid/tready      tdata = byte_in, tlast = string_end
// m_axis    out  m_axis_tvalid/tready      tdata = code_unit, tuser = replaced,
//                                          tlast = last_of_run
// cfg       in   cfg_valid/cfg_ready       cfg_data = first_only
//
// One byte is accepted per cycle while the queue has room; the first unit of a byte reaches
// m_axis through the input register, then the queue. A byte yields up to two units;
// the output side drains one unit per cycle while m_axis_tready is high.
// A four-entry result queue takes a new byte whenever two slots are free.
// rst is synchronous; it empties the input register and queue and clears state.

module utf8_to_utf16_transcoder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] code_unit
  output logic        m_axis_tuser,   // [0] replaced
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  logic             first_only;
  logic             room;
  u8u16_pkg::push_t push;
  u8u16_pkg::unit_t m_unit;

  // Configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      first_only <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      first_only <= cfg_data;
    end
  end

  u8u16_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .s_valid    (s_axis_tvalid),
    .s_ready    (s_axis_tready),
    .s_byte     (s_axis_tdata),
    .s_end      (s_axis_tlast),
    .first_only (first_only),
    .room       (room),
    .push       (push)
  );

  u8u16_outq u_outq (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .room    (room),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .m_unit  (m_unit)
  );

  assign m_axis_tdata = m_unit.code_unit;
  assign m_axis_tuser = m_unit.replaced;
  assign m_axis_tlast = m_unit.last_of_run;

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam logic [15:0] REPLACEMENT  = 16'hFFFD;
  localparam logic [15:0] HIGH_BASE    = 16'hD800;
  localparam logic [15:0] LOW_BASE     = 16'hDC00;
  localparam logic [20:0] PLANE1_START = 21'h10000;
  localparam logic [7:0]  FIRST_BAD    = 8'hF5;
  localparam int          STALL_LIMIT  = 1000;
  localparam int          HOLD_CYCLES  = 80;
  localparam int          SETTLE       = 4;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        replaced;
    logic        last_of_run;
  } utf16_unit_t;

  // One input byte; when given is set, the units that follow are the known answer
  typedef struct packed {
    logic        mode;
    logic [7:0]  b;
    logic        fin;
    logic        given;
    logic [1:0]  n;
    logic [15:0] c0;
    logic        r0;
    logic [15:0] c1;
    logic        r1;
  } byte_row_t;

  localparam int DIR_COUNT = 28;
  localparam byte_row_t DIR_ROWS [DIR_COUNT] = '{
    // single-byte forms, stray continuation, bad leads around the limit
    '{1'b0, 8'h00, 1'b1, 1'b1, 2'd1, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{1'b0, 8'h7F, 1'b0, 1'b1, 2'd1, 16'h007F, 1'b0, 16'h0000, 1'b0},
    '{1'b0, 8'h80, 1'b0, 1'b1, 2'd1, REPLACEMENT, 1'b1, 16'h0000, 1'b0},
    '{1'b0, 8'hFF, 1'b0, 1'b1, 2'd1, REPLACEMENT, 1'b1, 16'h0000, 1'b0},
    '{1'b0, 8'hF5, 1'b0, 1'b1, 2'd1, REPLACEMENT, 1'b1, 16'h0000, 1'b0},
    // properly encoded U+FFFD
    '{1'b0, 8'hEF, 1'b0, 1'b0, 2'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{1'b0, 8'hBF, 1'b0, 1'b0, 2'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{1'b0, 8'hBD, 1'b0, 1'b0, 2'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
    // surrogate pair
    '{1'b0, 8'hF0, 1'b0, 1'b0, 2'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{1'b0, 8'h9F, 1'b0, 1'b0, 2'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{1'b0, 8'h98, 1'b0, 1'b0, 2'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{1'b0, 8'h80, 1'b0, 1'b0, 2'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
    // four-byte value beyond the last plane
    '{1'b0, 8'hF4, 1'b0, 1'b0, 2'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{1'b0, 8'hBF, 1'b0, 1'b0, 2'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{1'b0, 8'hBF, 1'b0, 1'b0, 2'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{1'b0, 8'hBF, 1'b0, 1'b0, 2'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
    // broken sequence: substitute, then take the byte as a lead
    '{1'b0, 8'hE2, 1'b0, 1'b0, 2'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{1'b0, 8'h41, 1'b0, 1'b1, 2'd2, REPLACEMENT, 1'b1, 16'h0041, 1'b0},
    // sequence cut off by string end, lead cut off by string end
    '{1'b0, 8'hE2, 1'b0, 1'b0, 2'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{1'b0, 8'h82, 1'b1, 1'b1, 2'd1, REPLACEMENT, 1'b1, 16'h0000, 1'b0},
    '{1'b0, 8'hF0, 1'b1, 1'b1, 2'd1, REPLACEMENT, 1'b1, 16'h0000, 1'b0},
    '{1'b0, 8'hDF, 1'b0, 1'b0, 2'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{1'b0, 8'hBF, 1'b1, 1'b0, 2'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
    // first-only: rest of string dropped, broken first char not reprocessed
    '{1'b1, 8'h41, 1'b0, 1'b1, 2'd1, 16'h0041, 1'b0, 16'h0000, 1'b0},
    '{1'b1, 8'h42, 1'b1, 1'b1, 2'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{1'b1, 8'hE2, 1'b0, 1'b0, 2'd0, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{1'b1, 8'h41, 1'b0, 1'b1, 2'd1, REPLACEMENT, 1'b1, 16'h0000, 1'b0},
    // mode cleared mid-string: still dropped until string end
    '{1'b0, 8'h43, 1'b1, 1'b1, 2'd0, 16'h0000, 1'b0, 16'h0000, 1'b0}
  };

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] byte_in
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [15:0] code_unit
  logic        m_axis_tuser;   // [0] replaced
  logic        m_axis_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;

  // Decoder state mirrored by the bench
  logic        mode_first;
  logic [20:0] acc_point;
  logic [1:0]  cont_left;
  logic        char_done;

  utf16_unit_t step_units[$];
  utf16_unit_t units_due[$];

  logic idle_on;
  logic hold_req;
  int   mismatches;
  int   bytes_fed;
  int   strings_fed;
  int   units_seen;
  int   substitutions;
  int   high_halves;
  int   quiet_cycles;

  utf8_to_utf16_transcoder_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void add_unit(input logic [15:0] code, input logic repl);
    utf16_unit_t u;
    u.code_unit   = code;
    u.replaced    = repl;
    u.last_of_run = 1'b0;
    step_units.insert(step_units.size(), u);
  endfunction

  // Split anything above the basic plane into high and low halves
  function automatic void add_point(input logic [20:0] cp);
    logic [20:0] off;
    if (cp < PLANE1_START) begin
      add_unit(cp[15:0], 1'b0);
    end else begin
      off = cp - PLANE1_START;
      add_unit(HIGH_BASE + {5'd0, off[20:10]}, 1'b0);
      add_unit(LOW_BASE + {6'd0, off[9:0]}, 1'b0);
    end
  endfunction

  // Handle a byte that opens a character
  function automatic void start_char(input logic [7:0] b, input logic fin);
    if (!b[7]) begin
      add_unit({8'h00, b}, 1'b0);
    end else if (b < 8'hC0 || b >= FIRST_BAD) begin
      add_unit(REPLACEMENT, 1'b1);
    end else if (fin) begin
      acc_point = '0;
      cont_left = '0;
      add_unit(REPLACEMENT, 1'b1);
    end else if (b < 8'hE0) begin
      acc_point = {16'd0, b[4:0]};
      cont_left = 2'd1;
    end else if (b < 8'hF0) begin
      acc_point = {17'd0, b[3:0]};
      cont_left = 2'd2;
    end else begin
      acc_point = {18'd0, b[2:0]};
      cont_left = 2'd3;
    end
  endfunction

  // Advance the mirrored decoder by one byte and collect its units
  function automatic void predict_units(input logic [7:0] b, input logic fin);
    step_units = {};
    if (char_done) begin
      // drop the rest of the string
    end else if (cont_left != 2'd0) begin
      if (b[7:6] == 2'b10) begin
        acc_point = {acc_point[14:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left == 2'd0) begin
          add_point(acc_point);
          acc_point = '0;
        end else if (fin) begin
          add_unit(REPLACEMENT, 1'b1);
          acc_point = '0;
          cont_left = '0;
        end
      end else begin
        add_unit(REPLACEMENT, 1'b1);
        acc_point = '0;
        cont_left = '0;
        if (!mode_first) start_char(b, fin);
      end
    end else begin
      start_char(b, fin);
    end
    if (step_units.size() > 0 && mode_first) char_done = 1'b1;
    if (fin) begin
      acc_point = '0;
      cont_left = '0;
      char_done = 1'b0;
    end
  endfunction

  function automatic logic [7:0] lead_for(input int len);
    case (len)
      2:       lead_for = 8'($urandom_range(8'hC0, 8'hDF));
      3:       lead_for = 8'($urandom_range(8'hE0, 8'hEF));
      default: lead_for = 8'($urandom_range(8'hF0, 8'hF4));
    endcase
  endfunction

  // Offer one byte, wait for its transfer, then queue the units it should give
  task automatic feed(input byte_row_t r);
    utf16_unit_t u;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= r.b;
    s_axis_tlast  <= r.fin;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_units(r.b, r.fin);
    if (r.given) begin
      step_units = {};
      if (r.n > 2'd0) add_unit(r.c0, r.r0);
      if (r.n > 2'd1) add_unit(r.c1, r.r1);
    end
    foreach (step_units[k]) begin
      u = step_units[k];
      u.last_of_run = (k == step_units.size() - 1);
      units_due.insert(units_due.size(), u);
    end
    bytes_fed++;
    if (r.fin) strings_fed++;
  endtask

  // Stop offering, wait for every unit, then let the pipeline settle
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (units_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_mode(input logic v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    mode_first = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Build one string, mostly well-formed characters with some damage mixed in
  task automatic send_string(input int max_chars);
    logic [7:0] bq[$];
    byte_row_t  r;
    int         kind;
    int         len;
    repeat ($urandom_range(1, max_chars)) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        bq.insert(bq.size(), 8'($urandom_range(0, 8'h7F)));
      end else if (kind < 75) begin
        len = (kind < 45) ? 2 : (kind < 60) ? 3 : 4;
        bq.insert(bq.size(), lead_for(len));
        repeat (len - 1) bq.insert(bq.size(), 8'($urandom_range(8'h80, 8'hBF)));
      end else if (kind < 80) begin
        bq.insert(bq.size(), 8'($urandom_range(8'h80, 8'hBF)));
      end else if (kind < 85) begin
        bq.insert(bq.size(), 8'($urandom_range(FIRST_BAD, 8'hFF)));
      end else if (kind < 93) begin
        // truncated sequence: fewer continuations than the lead asks for
        len = $urandom_range(2, 4);
        bq.insert(bq.size(), lead_for(len));
        repeat ($urandom_range(0, len - 2))
          bq.insert(bq.size(), 8'($urandom_range(8'h80, 8'hBF)));
      end else begin
        bq.insert(bq.size(), 8'($urandom_range(0, 255)));
      end
    end
    foreach (bq[k]) begin
      r = '0;
      r.b = bq[k];
      r.fin = (k == bq.size() - 1);
      feed(r);
    end
  endtask

  // Output side: random stalls, plus one long hold on request
  initial begin
    int hold_left;
    int stall_left;
    hold_left = 0;
    stall_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 3);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Compare each output transfer with the oldest expected unit
  always @(posedge clk) begin
    utf16_unit_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      units_seen++;
      if (m_axis_tuser) substitutions++;
      if (m_axis_tdata[15:10] == HIGH_BASE[15:10]) high_halves++;
      if (units_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected unit: expected none, actual code %h repl %b last %b",
                 $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
      end else begin
        want = units_due.pop_front();
        if (m_axis_tdata !== want.code_unit) begin
          mismatches++;
          $display("%0t: code_unit expected %h actual %h", $time, want.code_unit, m_axis_tdata);
        end
        if (m_axis_tuser !== want.replaced) begin
          mismatches++;
          $display("%0t: replaced expected %b actual %b", $time, want.replaced, m_axis_tuser);
        end
        if (m_axis_tlast !== want.last_of_run) begin
          mismatches++;
          $display("%0t: last_of_run expected %b actual %b", $time, want.last_of_run,
                   m_axis_tlast);
        end
      end
    end
  end

  // Watchdog: end the run after a long stretch with no transfer anywhere
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d units outstanding", $time, STALL_LIMIT,
                 units_due.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    int start;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    idle_on = 1'b1;
    hold_req = 1'b0;
    mode_first = 1'b0;
    acc_point = '0;
    cont_left = '0;
    char_done = 1'b0;
    mismatches = 0;
    bytes_fed = 0;
    strings_fed = 0;
    units_seen = 0;
    substitutions = 0;
    high_halves = 0;
    quiet_cycles = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table; switch mode only once the block has gone quiet
    for (int i = 0; i < DIR_COUNT; i++) begin
      if (i == 0 || DIR_ROWS[i].mode != mode_first) begin
        drain();
        write_mode(DIR_ROWS[i].mode);
      end
      feed(DIR_ROWS[i]);
    end

    // Random phases: alternate modes, long output hold in the third, no idling in the last
    for (int p = 0; p < 4; p++) begin
      drain();
      write_mode((p % 2) == 1);
      idle_on = (p != 3);
      if (p == 2) hold_req = 1'b1;
      start = bytes_fed;
      while (bytes_fed - start < ((p == 0) ? 250 : 150)) send_string(((p % 2) == 1) ? 3 : 8);
    end
    drain();

    $display("Run: %0d bytes in %0d strings, %0d code units out, %0d substituted, %0d pairs",
             bytes_fed, strings_fed, units_seen, substitutions, high_halves);
    $display("Both modes, broken and cut-off sequences, long output hold; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/u8u16_pkg.sv
rtl/core/u8u16_decode.sv
rtl/core/u8u16_outq.sv
rtl/core/utf8_to_utf16_transcoder_top.sv
bench/testbench.sv
